// ----- rtl/cdnc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cdnc_pkg
// Shared types, constants and helpers for the calendar day number converter.
// ============================================================================
package cdnc_pkg;

    localparam int DN_W   = 22;
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int WD_W   = 3;
    localparam int DOY_W  = 9;
    localparam int STAGES = 6;

    localparam logic [DN_W-1:0] DN_FIELD_MAX = 22'h3FFFFF;

    // y / 100 == (y * RECIP_100) >> RECIP_100_SH for all 14-bit y
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [YEAR_W-1:0] HUNDRED = 14'd100;

    // floor(2^32 * 400 / 146097), year estimate from a day number
    localparam logic [23:0] RECIP_YEAR = 24'd11759221;

    // 31 * (m - 1) minus the March-onward correction, month 0 as minus one
    localparam logic signed [9:0] MONTH_OFFSET [16] = '{
        -10'sd31, 10'sd0,   10'sd31,  10'sd59,  10'sd90,  10'sd120, 10'sd151, 10'sd181,
        10'sd212, 10'sd243, 10'sd273, 10'sd304, 10'sd334, 10'sd365, 10'sd396, 10'sd426
    };

    // last day of year of each month, common year
    localparam logic [DOY_W-1:0] MONTH_END [16] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181, 9'd212,
        9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd0,   9'd0,   9'd0
    };

    // days before the first of each month, common year
    localparam logic [DOY_W-1:0] MONTH_START [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    typedef struct packed {
        logic [DN_W-1:0]   day_number;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [WD_W-1:0]   weekday;
        logic              valid;
    } cdnc_res_t;

    // fold octal digits, since 8 == 1 mod 7
    function automatic logic [WD_W-1:0] mod7(input logic [23:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        mod7 = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

// ----- rtl/cdnc_fwd.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cdnc_fwd
// Date to day number datapath: three compute stages, then alignment stages.
// ============================================================================
module cdnc_fwd #(
    parameter int MAX_DAY_NUMBER = 3652424
) (
    input  logic                                aclk,
    input  logic [cdnc_pkg::STAGES-1:0]         stage_en,
    input  logic [cdnc_pkg::YEAR_W-1:0]         year,
    input  logic [cdnc_pkg::MON_W-1:0]          month,
    input  logic [cdnc_pkg::DAY_W-1:0]          day,
    input  logic                                sun_start,
    output cdnc_pkg::cdnc_res_t                 res
);

    localparam logic [cdnc_pkg::DN_W-1:0] MAX_DN = 22'(MAX_DAY_NUMBER);

    logic                               le2;
    logic                               neg;
    logic [cdnc_pkg::YEAR_W-1:0]        yp;
    logic signed [9:0]                  moff;

    logic                               zero_next, zero_reg;
    logic [cdnc_pkg::YEAR_W-1:0]        ypos_next, ypos_reg;
    logic [26:0]                        prod_next, prod_reg;
    logic signed [23:0]                 base_next, base_reg;
    logic                               sf1_reg;

    logic [7:0]                         q100;
    logic [11:0]                        leap_days;
    logic signed [23:0]                 r_next, r_reg;
    logic                               sf2_reg;

    logic [22:0]                        ur;
    logic                               sat;
    cdnc_pkg::cdnc_res_t                res_next;
    cdnc_pkg::cdnc_res_t                res_reg [4];

    always_comb begin
        le2       = month <= 4'd2;
        neg       = le2 && (year == '0);
        yp        = le2 ? year - 14'd1 : year;
        ypos_next = neg ? '0 : yp;
        moff      = cdnc_pkg::MONTH_OFFSET[month];
        zero_next = (year == '0) && (month == '0);
        prod_next = {13'b0, ypos_next} * {14'b0, cdnc_pkg::RECIP_100};
        base_next = $signed({10'b0, year}) * 24'sd365
                  + $signed({{14{moff[9]}}, moff})
                  + $signed({19'b0, day});
    end

    always_comb begin
        q100      = prod_reg[26:cdnc_pkg::RECIP_100_SH];
        leap_days = 12'(ypos_reg[13:2]) - 12'(q100) + 12'(q100[7:2]);
        r_next    = zero_reg ? '0 : base_reg + $signed({12'b0, leap_days});
    end

    always_comb begin
        ur  = r_reg[23] ? '0 : r_reg[22:0];
        sat = ur > {1'b0, cdnc_pkg::DN_FIELD_MAX};
        res_next            = '0;
        res_next.day_number = sat ? cdnc_pkg::DN_FIELD_MAX : ur[21:0];
        res_next.weekday    = cdnc_pkg::mod7({1'b0, ur} + 24'd5 + {23'b0, sf2_reg});
        res_next.valid      = (ur != '0) && !sat && (ur[21:0] <= MAX_DN);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            zero_reg <= zero_next;
            ypos_reg <= ypos_next;
            prod_reg <= prod_next;
            base_reg <= base_next;
            sf1_reg  <= sun_start;
        end
        if (stage_en[1]) begin
            r_reg   <= r_next;
            sf2_reg <= sf1_reg;
        end
        if (stage_en[2]) begin
            res_reg[0] <= res_next;
        end
        if (stage_en[3]) begin
            res_reg[1] <= res_reg[0];
        end
        if (stage_en[4]) begin
            res_reg[2] <= res_reg[1];
        end
        if (stage_en[5]) begin
            res_reg[3] <= res_reg[2];
        end
    end

    assign res = res_reg[3];

endmodule

// ----- rtl/cdnc_rev.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cdnc_rev
// Day number to date datapath: year estimate, year correction, leap fix and
// month search over six register stages.
// ============================================================================
module cdnc_rev #(
    parameter int MAX_DAY_NUMBER = 3652424
) (
    input  logic                                aclk,
    input  logic [cdnc_pkg::STAGES-1:0]         stage_en,
    input  logic [cdnc_pkg::DN_W-1:0]           day_number,
    input  logic                                sun_start,
    output cdnc_pkg::cdnc_res_t                 res
);

    localparam logic [cdnc_pkg::DN_W-1:0] MAX_DN = 22'(MAX_DAY_NUMBER);

    typedef struct packed {
        logic [cdnc_pkg::DN_W-1:0] dn;
        logic                      in_range;
        logic [cdnc_pkg::WD_W-1:0] wd;
    } rev_carry_t;

    rev_carry_t                         carry_next;
    rev_carry_t                         carry_reg [cdnc_pkg::STAGES];

    // stage 1
    logic [45:0]                        est_prod;
    logic [cdnc_pkg::YEAR_W-1:0]        c_next, c1_reg, c2_reg;

    // stage 2
    logic signed [15:0]                 k_val [3];
    logic [cdnc_pkg::YEAR_W-1:0]        kc_next [3];
    logic [cdnc_pkg::YEAR_W-1:0]        kc_reg [3];
    logic [26:0]                        prodk_next [3];
    logic [26:0]                        prodk_reg [3];

    // stage 3
    logic [7:0]                         qk [3];
    logic [11:0]                        lk [3];
    logic signed [15:0]                 yk [3];
    logic signed [23:0]                 before_next [3];
    logic signed [23:0]                 before_reg [3];
    logic [cdnc_pkg::YEAR_W-1:0]        c3_reg;

    // stage 4
    logic signed [23:0]                 dn_s;
    logic signed [23:0]                 b_sel;
    logic signed [23:0]                 doy_wide;
    logic [cdnc_pkg::YEAR_W-1:0]        y_next, y4_reg, y5_reg, y6_reg;
    logic [cdnc_pkg::DOY_W-1:0]         doy_next, doy4_reg, doy5_reg;

    // stage 5
    logic [26:0]                        prody_next, prody_reg;

    // stage 6
    logic [7:0]                         qy;
    logic [cdnc_pkg::YEAR_W-1:0]        hund;
    logic                               leap;
    logic [cdnc_pkg::DOY_W-1:0]         doy6_next, doy6_reg;
    logic                               lday_next, lday_reg;

    // month search
    logic [cdnc_pkg::MON_W-1:0]         mon;
    logic [cdnc_pkg::DOY_W-1:0]         dom;

    always_comb begin
        carry_next.dn       = day_number;
        carry_next.in_range = (day_number != '0) && (day_number <= MAX_DN);
        carry_next.wd       = cdnc_pkg::mod7({2'b0, day_number} + 24'd5 + {23'b0, sun_start});
        est_prod            = {24'b0, day_number} * {22'b0, cdnc_pkg::RECIP_YEAR};
        c_next              = est_prod[45:32];
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            k_val[j]      = $signed({2'b00, c1_reg}) + 16'(j) - 16'sd2;
            kc_next[j]    = k_val[j][15] ? '0 : k_val[j][13:0];
            prodk_next[j] = {13'b0, kc_next[j]} * {14'b0, cdnc_pkg::RECIP_100};
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qk[j]          = prodk_reg[j][26:cdnc_pkg::RECIP_100_SH];
            lk[j]          = 12'(kc_reg[j][13:2]) - 12'(qk[j]) + 12'(qk[j][7:2]);
            yk[j]          = $signed({2'b00, c2_reg}) + 16'(j) - 16'sd1;
            before_next[j] = $signed({{8{yk[j][15]}}, yk[j]}) * 24'sd365
                           + $signed({12'b0, lk[j]}) + 24'sd1;
        end
    end

    always_comb begin
        dn_s = $signed({2'b00, carry_reg[2].dn});
        if (dn_s < before_reg[1]) begin
            y_next = c3_reg - 14'd1;
            b_sel  = before_reg[0];
        end else if (dn_s >= before_reg[2]) begin
            y_next = c3_reg + 14'd1;
            b_sel  = before_reg[2];
        end else begin
            y_next = c3_reg;
            b_sel  = before_reg[1];
        end
        doy_wide = dn_s - b_sel + 24'sd1;
        doy_next = doy_wide[cdnc_pkg::DOY_W-1:0];
    end

    assign prody_next = {13'b0, y4_reg} * {14'b0, cdnc_pkg::RECIP_100};

    always_comb begin
        qy   = prody_reg[26:cdnc_pkg::RECIP_100_SH];
        hund = 14'({6'b0, qy} * cdnc_pkg::HUNDRED);
        leap = (y5_reg[1:0] == 2'b00) && ((y5_reg != hund) || (qy[1:0] == 2'b00));
        if (leap && (doy5_reg > 9'd59)) begin
            doy6_next = doy5_reg - 9'd1;
            lday_next = doy5_reg == 9'd60;
        end else begin
            doy6_next = doy5_reg;
            lday_next = 1'b0;
        end
    end

    always_comb begin
        mon = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (doy6_reg > cdnc_pkg::MONTH_END[k]) begin
                mon = 4'(k + 1);
            end
        end
        dom = doy6_reg - cdnc_pkg::MONTH_START[mon] + {8'b0, lday_reg};

        res            = '0;
        res.day_number = carry_reg[5].dn;
        res.weekday    = carry_reg[5].wd;
        res.valid      = carry_reg[5].in_range;
        if (carry_reg[5].in_range) begin
            res.year  = y6_reg;
            res.month = mon;
            res.day   = dom[cdnc_pkg::DAY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            carry_reg[0] <= carry_next;
            c1_reg       <= c_next;
        end
        if (stage_en[1]) begin
            carry_reg[1] <= carry_reg[0];
            c2_reg       <= c1_reg;
            kc_reg       <= kc_next;
            prodk_reg    <= prodk_next;
        end
        if (stage_en[2]) begin
            carry_reg[2] <= carry_reg[1];
            c3_reg       <= c2_reg;
            before_reg   <= before_next;
        end
        if (stage_en[3]) begin
            carry_reg[3] <= carry_reg[2];
            y4_reg       <= y_next;
            doy4_reg     <= doy_next;
        end
        if (stage_en[4]) begin
            carry_reg[4] <= carry_reg[3];
            y5_reg       <= y4_reg;
            doy5_reg     <= doy4_reg;
            prody_reg    <= prody_next;
        end
        if (stage_en[5]) begin
            carry_reg[5] <= carry_reg[4];
            y6_reg       <= y5_reg;
            doy6_reg     <= doy6_next;
            lday_reg     <= lday_next;
        end
    end

endmodule

// ----- rtl/calendar_day_number_convert_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// calendar_day_number_convert_top
// Converts between a Gregorian date and a running day number, both ways.
// ============================================================================
// Throughput: one word per cycle while m_axis_tready is high; the pipeline holds seven words.
// Each stage advances when it is empty or the next stage advances, so
// bubbles fill while the output word waits.
// Reset clears the valid bit of every stage; data registers are not reset.
module calendar_day_number_convert_top #(
    parameter int MAX_DAY_NUMBER = 3652424
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] year, [17:14] month, [22:18] day, [44:23] day_number,
    // [45] sun_start, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    // [0] func
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [21:0] out_day_number, [35:22] out_year, [39:36] out_month,
    // [44:40] out_day, [47:45] weekday
    output logic [47:0] m_axis_tdata,
    // [0] valid_res
    output logic [0:0]  m_axis_tuser
);

    localparam int NSTG = cdnc_pkg::STAGES + 1;

    logic [NSTG-1:0]             stage_en;
    logic [NSTG-1:0]             valid_next, valid_reg;
    logic [cdnc_pkg::STAGES-1:0] func_reg;

    cdnc_pkg::cdnc_res_t         fwd_res;
    cdnc_pkg::cdnc_res_t         rev_res;
    cdnc_pkg::cdnc_res_t         out_next, out_reg;

    always_comb begin
        stage_en[NSTG-1] = !valid_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = s_axis_tvalid;
        for (int i = 1; i < NSTG; i++) begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    assign s_axis_tready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            func_reg[0] <= s_axis_tuser[0];
        end
        for (int i = 1; i < cdnc_pkg::STAGES; i++) begin
            if (stage_en[i]) begin
                func_reg[i] <= func_reg[i-1];
            end
        end
    end

    cdnc_fwd #(
        .MAX_DAY_NUMBER (MAX_DAY_NUMBER)
    ) u_fwd (
        .aclk         (aclk),
        .stage_en     (stage_en[cdnc_pkg::STAGES-1:0]),
        .year         (s_axis_tdata[13:0]),
        .month        (s_axis_tdata[17:14]),
        .day          (s_axis_tdata[22:18]),
        .sun_start    (s_axis_tdata[45]),
        .res          (fwd_res)
    );

    cdnc_rev #(
        .MAX_DAY_NUMBER (MAX_DAY_NUMBER)
    ) u_rev (
        .aclk         (aclk),
        .stage_en     (stage_en[cdnc_pkg::STAGES-1:0]),
        .day_number   (s_axis_tdata[44:23]),
        .sun_start    (s_axis_tdata[45]),
        .res          (rev_res)
    );

    assign out_next = func_reg[cdnc_pkg::STAGES-1] ? rev_res : fwd_res;

    always_ff @(posedge aclk) begin
        if (stage_en[NSTG-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = {out_reg.weekday, out_reg.day, out_reg.month,
                            out_reg.year, out_reg.day_number};
    assign m_axis_tuser  = out_reg.valid;

endmodule

// ----- rtl/cdnc_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cdnc_checker
// Port-level checks on the converter's result stream.
// ============================================================================
module cdnc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_valid_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[21:0] != 22'd0)
        else $error("valid result with day number zero");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[47:45] != 3'd7)
        else $error("weekday out of range");

    a_month_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[39:36] != 4'd0) |-> m_axis_tuser[0])
        else $error("date fields set on an invalid result");

endmodule

bind calendar_day_number_convert_top cdnc_checker u_cdnc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
